@@ rtl/tmd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmd_pkg
// Shared types and constants of the type-length-value stream deframer.
// ----------------------------------------------------------------------------
package tmd_pkg;

   localparam int TYPE_BYTES  = 4;
   localparam int LEN_DIGITS  = 4;
   localparam int HDR_BYTES   = TYPE_BYTES + LEN_DIGITS;
   localparam int HDR_CNT_W   = (HDR_BYTES > 2) ? $clog2(HDR_BYTES) : 1;

   localparam int BYTE_W      = 8;
   localparam int TYPE_W      = 32;
   localparam int LEN_W       = 16;
   localparam int DIGIT_W     = 4;

   // The queue depth is a power of two so that the pointers wrap on their own.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic       FUNC_STREAM  = 1'b0;
   localparam logic       FUNC_FLUSH   = 1'b1;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   typedef struct packed {
      logic              func;
      logic [BYTE_W-1:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [TYPE_W-1:0] msg_type;
      logic [LEN_W-1:0]  msg_length;
      logic [BYTE_W-1:0] out_byte;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

@@ rtl/tmd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmd_front
// Header parser: collects type bytes, decodes the hex length field and tags
// payload bytes, pushing each result into the queue.
// ----------------------------------------------------------------------------
module tmd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  tmd_pkg::req_type          req_data,
   input  tmd_pkg::queue_status_type queue_status,
   output logic                      push,
   output tmd_pkg::rsp_type          push_data
);

   localparam logic PHASE_HEADER  = 1'b0;
   localparam logic PHASE_PAYLOAD = 1'b1;

   logic                            phase_ff, phase_in;
   logic [tmd_pkg::HDR_CNT_W-1:0]   count_ff, count_in;
   logic [tmd_pkg::TYPE_W-1:0]      type_ff, type_in;
   logic [tmd_pkg::LEN_W-1:0]       accum_ff, accum_in;
   logic [tmd_pkg::LEN_W-1:0]       remaining_ff, remaining_in;
   logic                            digit_ff, digit_in;
   logic                            trail_ff, trail_in;
   logic                            bad_ff, bad_in;

   logic                            fire;
   logic                            clear;
   logic                            fin;
   logic [tmd_pkg::BYTE_W-1:0]      c;
   logic                            is_space;
   logic                            is_dec;
   logic                            is_alpha;
   logic                            hex_valid;
   logic [tmd_pkg::DIGIT_W-1:0]     hex_val;
   logic                            in_type_field;

   assign req_ready = !queue_status.full;
   assign fire      = req_valid && req_ready;
   assign c         = req_data.in_byte;

   assign is_space  = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   assign is_dec    = (c >= 8'h30) && (c <= 8'h39);
   assign is_alpha  = ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
   assign hex_valid = is_dec || is_alpha;
   assign hex_val   = is_dec ? c[3:0] : 4'(c[3:0] + 4'd9);
   assign fin       = (remaining_ff <= tmd_pkg::LEN_W'(1));

   assign in_type_field = ({1'b0, count_ff} < (tmd_pkg::HDR_CNT_W + 1)'(tmd_pkg::TYPE_BYTES));

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      type_in      = type_ff;
      accum_in     = accum_ff;
      remaining_in = remaining_ff;
      digit_in     = digit_ff;
      trail_in     = trail_ff;
      bad_in       = bad_ff;
      clear        = 1'b0;
      push         = 1'b0;
      push_data    = '0;

      if (fire) begin
         if (req_data.func == tmd_pkg::FUNC_FLUSH) begin
            clear = 1'b1;
         end else if (phase_ff == PHASE_PAYLOAD) begin
            push                 = 1'b1;
            push_data.kind       = tmd_pkg::KIND_PAYLOAD;
            push_data.msg_type   = type_ff;
            push_data.msg_length = accum_ff;
            push_data.out_byte   = c;
            push_data.last       = fin;
            remaining_in         = remaining_ff - tmd_pkg::LEN_W'(1);
            clear                = fin;
         end else begin
            if (in_type_field) begin
               type_in = {type_ff[tmd_pkg::TYPE_W-tmd_pkg::BYTE_W-1:0], c};
            end else if (is_space) begin
               if (digit_ff) begin
                  trail_in = 1'b1;
               end
            end else if (hex_valid) begin
               if (trail_ff) begin
                  bad_in = 1'b1;
               end else begin
                  if (accum_ff > 16'h0FFF) begin
                     bad_in = 1'b1;
                  end
                  accum_in = {accum_ff[tmd_pkg::LEN_W-tmd_pkg::DIGIT_W-1:0], hex_val};
                  digit_in = 1'b1;
               end
            end else begin
               bad_in = 1'b1;
            end
            count_in = count_ff + tmd_pkg::HDR_CNT_W'(1);

            if (count_ff == tmd_pkg::HDR_CNT_W'(tmd_pkg::HDR_BYTES - 1)) begin
               if (bad_in || !digit_in) begin
                  push               = 1'b1;
                  push_data.kind     = tmd_pkg::KIND_ERROR;
                  push_data.msg_type = type_in;
                  push_data.last     = 1'b1;
                  clear              = 1'b1;
               end else if (accum_in == '0) begin
                  push               = 1'b1;
                  push_data.kind     = tmd_pkg::KIND_EMPTY;
                  push_data.msg_type = type_in;
                  push_data.last     = 1'b1;
                  clear              = 1'b1;
               end else begin
                  phase_in     = PHASE_PAYLOAD;
                  remaining_in = accum_in;
                  count_in     = '0;
               end
            end
         end
      end

      if (clear) begin
         phase_in     = PHASE_HEADER;
         count_in     = '0;
         type_in      = '0;
         accum_in     = '0;
         remaining_in = '0;
         digit_in     = 1'b0;
         trail_in     = 1'b0;
         bad_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_HEADER;
         count_ff     <= '0;
         type_ff      <= '0;
         accum_ff     <= '0;
         remaining_ff <= '0;
         digit_ff     <= 1'b0;
         trail_ff     <= 1'b0;
         bad_ff       <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         type_ff      <= type_in;
         accum_ff     <= accum_in;
         remaining_ff <= remaining_in;
         digit_ff     <= digit_in;
         trail_ff     <= trail_in;
         bad_ff       <= bad_in;
      end
   end

endmodule

@@ rtl/tmd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmd_queue
// Two-entry result queue between the header parser and the output stage.
// ----------------------------------------------------------------------------
module tmd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tmd_pkg::rsp_type          push_data,
   input  logic                      pop,
   output tmd_pkg::rsp_type          head_data,
   output tmd_pkg::queue_status_type queue_status
);

   tmd_pkg::rsp_type             entry_ff [tmd_pkg::QUEUE_DEPTH];
   logic [tmd_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [tmd_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [tmd_pkg::QCNT_W-1:0]   count_ff, count_in;

   assign queue_status.full      = (count_ff == tmd_pkg::QCNT_W'(tmd_pkg::QUEUE_DEPTH));
   assign queue_status.not_empty = (count_ff != '0);
   assign head_data              = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + tmd_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + tmd_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + tmd_pkg::QCNT_W'(push) - tmd_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/tmd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmd_back
// Output stage: pulls results from the queue into the response register.
// ----------------------------------------------------------------------------
module tmd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  tmd_pkg::queue_status_type queue_status,
   input  tmd_pkg::rsp_type          head_data,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output tmd_pkg::rsp_type          rsp_data
);

   logic             valid_ff, valid_in;
   tmd_pkg::rsp_type data_ff, data_in;
   logic             load;

   assign load      = !valid_ff || rsp_ready;
   assign pop       = queue_status.not_empty && load;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      data_in = pop ? head_data : data_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

@@ rtl/text_message_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_message_deframer
// Type-length-value deframer for a byte stream with a hex-text length field.
// ----------------------------------------------------------------------------
// One byte is taken per cycle, and each transfer's result, if any, is written
// into the queue and then into the response register. A two-entry result queue
// and the response register let the parser keep taking bytes while a result
// waits; the input stalls only when the queue is full, so throughput is one
// byte per cycle whenever the result side takes its transfers.
module text_message_deframer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tmd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tmd_pkg::rsp_type rsp_data
);

   tmd_pkg::queue_status_type queue_status;
   tmd_pkg::rsp_type          push_data;
   tmd_pkg::rsp_type          head_data;
   logic                      push;
   logic                      pop;

   tmd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   tmd_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_data    (push_data),
      .pop          (pop),
      .head_data    (head_data),
      .queue_status (queue_status)
   );

   tmd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head_data    (head_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && queue_status.full))
      else $error("Result pushed into a full queue.");

   a_flush_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.func == tmd_pkg::FUNC_FLUSH) |-> !push)
      else $error("Flush transfer produced a result.");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> queue_status.not_empty)
      else $error("Output stage popped an empty queue.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid right after reset.");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the type-length-value stream deframer. A short table
// of header and payload bytes runs first, then random frames (well-formed,
// broken, noise and flushes) under varying sender gaps and receiver stalls.
// Every result transfer is compared with its pinned table value or with a local parser of the stream.
// ----------------------------------------------------------------------------
module tb;
   import tmd_pkg::*;

   localparam int ITEM_GOAL    = 1650;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 16;
   localparam int DIR_ROWS     = 43;

   localparam rsp_type NO_PIN = '0;

   typedef struct {
      logic              func;
      logic [BYTE_W-1:0] in_byte;
      bit                pinned;
      rsp_type           want;
   } dir_row_type;

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{FUNC_STREAM, 8'hFF, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h00, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'hFF, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h00, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h20, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h31, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h20, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h32, 1'b1, '{KIND_ERROR, 32'hFF00FF00, 16'h0000, 8'h00, 1'b1}},
      '{FUNC_STREAM, 8'h54, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h4C, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h56, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h21, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h2B, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h30, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h30, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h31, 1'b1, '{KIND_ERROR, 32'h544C5621, 16'h0000, 8'h00, 1'b1}},
      '{FUNC_STREAM, 8'h7F, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h80, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h01, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'hFE, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h20, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h0B, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h0C, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h0A, 1'b1, '{KIND_ERROR, 32'h7F8001FE, 16'h0000, 8'h00, 1'b1}},
      '{FUNC_STREAM, 8'h00, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h00, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h00, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h00, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h09, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h30, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h20, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h0D, 1'b1, '{KIND_EMPTY, 32'h00000000, 16'h0000, 8'h00, 1'b1}},
      '{FUNC_STREAM, 8'h01, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h02, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h03, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h04, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h66, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h46, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h66, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h46, 1'b0, NO_PIN},
      '{FUNC_STREAM, 8'h00, 1'b1, '{KIND_PAYLOAD, 32'h01020304, 16'hFFFF, 8'h00, 1'b0}},
      '{FUNC_STREAM, 8'hFF, 1'b1, '{KIND_PAYLOAD, 32'h01020304, 16'hFFFF, 8'hFF, 1'b0}},
      '{FUNC_FLUSH,  8'hA5, 1'b0, NO_PIN}
   };

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   logic              in_payload;
   int                hdr_count;
   logic [TYPE_W-1:0] type_acc;
   logic [LEN_W-1:0]  len_acc;
   logic [LEN_W-1:0]  bytes_left;
   logic              saw_digit;
   logic              saw_trail;
   logic              len_bad;

   rsp_type results_due [$];
   int      bytes_sent     = 0;
   int      bad_fields     = 0;
   int      send_idle_pct  = 0;
   int      recv_stall_pct = 0;
   int      quiet_cycles   = 0;

   text_message_deframer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic void clear_parser();
      in_payload = 1'b0;
      hdr_count  = 0;
      type_acc   = '0;
      len_acc    = '0;
      bytes_left = '0;
      saw_digit  = 1'b0;
      saw_trail  = 1'b0;
      len_bad    = 1'b0;
   endfunction

   function automatic int hex_digit(logic [BYTE_W-1:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      return -1;
   endfunction

   function automatic bit parse_byte(input req_type r, output rsp_type o);
      logic [BYTE_W-1:0] c;
      logic              fin;
      logic              ws;
      int                v;
      c = r.in_byte;
      o = '0;
      if (r.func == FUNC_FLUSH) begin
         clear_parser();
         return 1'b0;
      end
      if (in_payload) begin
         fin = (bytes_left <= 16'd1);
         o = '{KIND_PAYLOAD, type_acc, len_acc, c, fin};
         bytes_left = bytes_left - 16'd1;
         if (fin) clear_parser();
         return 1'b1;
      end
      if (hdr_count < TYPE_BYTES) begin
         type_acc = {type_acc[TYPE_W-BYTE_W-1:0], c};
      end else begin
         v  = hex_digit(c);
         ws = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
         if (ws) begin
            if (saw_digit) saw_trail = 1'b1;
         end else if (v >= 0) begin
            if (saw_trail) begin
               len_bad = 1'b1;
            end else begin
               if (len_acc > 16'h0FFF) len_bad = 1'b1;
               len_acc   = {len_acc[LEN_W-DIGIT_W-1:0], v[DIGIT_W-1:0]};
               saw_digit = 1'b1;
            end
         end else begin
            len_bad = 1'b1;
         end
      end
      hdr_count++;
      if (hdr_count < HDR_BYTES) return 1'b0;
      if (len_bad || !saw_digit) begin
         o = '{KIND_ERROR, type_acc, 16'h0000, 8'h00, 1'b1};
         clear_parser();
         return 1'b1;
      end
      if (len_acc == '0) begin
         o = '{KIND_EMPTY, type_acc, 16'h0000, 8'h00, 1'b1};
         clear_parser();
         return 1'b1;
      end
      in_payload = 1'b1;
      bytes_left = len_acc;
      hdr_count  = 0;
      return 1'b0;
   endfunction

   task automatic send_req(input req_type r, input bit pinned = 1'b0,
                           input rsp_type want = '0);
      rsp_type got;
      bit      has_result;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (!req_ready);
      has_result = parse_byte(r, got);
      if (pinned) results_due.push_back(want);
      else if (has_result) results_due.push_back(got);
      bytes_sent++;
      @(negedge clock);
   endtask

   function automatic logic [BYTE_W-1:0] pad_char();
      if ($urandom_range(0, 5) == 0) return 8'h20;
      return 8'(8 + $urandom_range(1, 5));
   endfunction

   function automatic logic [BYTE_W-1:0] digit_char(logic [DIGIT_W-1:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      if ($urandom_range(0, 1) == 1) return 8'h41 + 8'(v) - 8'd10;
      return 8'h61 + 8'(v) - 8'd10;
   endfunction

   task automatic send_frame(input bit broken);
      logic [LEN_W-1:0]  len;
      logic [BYTE_W-1:0] fld [LEN_DIGITS];
      int                pick;
      int                n_dig;
      int                lead;
      int                cut;
      int                k;
      pick = $urandom_range(0, 99);
      if (pick < 15) len = '0;
      else if (pick < 70) len = 16'($urandom_range(1, 6));
      else if (pick < 90) len = 16'($urandom_range(7, 40));
      else len = 16'($urandom);
      n_dig = (len < 16'h10) ? 1 : (len < 16'h100) ? 2 : (len < 16'h1000) ? 3 : 4;
      n_dig = $urandom_range(LEN_DIGITS, n_dig);
      lead  = $urandom_range(0, LEN_DIGITS - n_dig);
      for (k = 0; k < LEN_DIGITS; k++) fld[k] = pad_char();
      for (k = 0; k < n_dig; k++) begin
         fld[lead + k] = digit_char(DIGIT_W'(len >> (DIGIT_W * (n_dig - 1 - k))));
      end
      if (broken) begin
         case ($urandom_range(0, 3))
            0: fld[$urandom_range(0, LEN_DIGITS - 1)] = 8'($urandom);
            1: for (k = 0; k < LEN_DIGITS; k++) fld[k] = pad_char();
            2: fld[$urandom_range(0, LEN_DIGITS - 1)] = $urandom_range(0, 1) ? 8'h2D : 8'h2B;
            default: begin
               fld[0] = digit_char(4'($urandom));
               fld[1] = pad_char();
               fld[2] = digit_char(4'($urandom));
               fld[3] = $urandom_range(0, 1) ? pad_char() : digit_char(4'($urandom));
            end
         endcase
      end
      if (in_payload || hdr_count != 0) send_req('{FUNC_FLUSH, 8'($urandom)});
      for (k = 0; k < TYPE_BYTES; k++) send_req('{FUNC_STREAM, 8'($urandom)});
      for (k = 0; k < LEN_DIGITS; k++) send_req('{FUNC_STREAM, fld[k]});
      if (in_payload) begin
         cut = bytes_left;
         if (bytes_left > 16'd40) cut = $urandom_range(1, 8);
         else if ($urandom_range(0, 19) == 0) cut = $urandom_range(0, int'(bytes_left) - 1);
         for (k = 0; k < cut; k++) send_req('{FUNC_STREAM, 8'($urandom)});
         if (in_payload) send_req('{FUNC_FLUSH, 8'($urandom)});
      end
   endtask

   task automatic flag_field(input string name, input logic [TYPE_W-1:0] want,
                             input logic [TYPE_W-1:0] got);
      if (want !== got) begin
         if (bad_fields < 10) $display("tb: %s expected %h, got %h", name, want, got);
         bad_fields++;
      end
   endtask

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            if (bad_fields < 10) $display("tb: result transfer with none due: %h", rsp_data);
            bad_fields++;
         end else begin
            want = results_due.pop_front();
            flag_field("kind", want.kind, rsp_data.kind);
            flag_field("msg_type", want.msg_type, rsp_data.msg_type);
            flag_field("msg_length", want.msg_length, rsp_data.msg_length);
            flag_field("out_byte", want.out_byte, rsp_data.out_byte);
            flag_field("last", want.last, rsp_data.last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int pick;
      int i;
      int k;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      clear_parser();
      repeat (12) @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < DIR_ROWS; i++) begin
         send_req('{dir_rows[i].func, dir_rows[i].in_byte}, dir_rows[i].pinned,
                  dir_rows[i].want);
      end

      while (bytes_sent < ITEM_GOAL) begin
         case ((bytes_sent * 4) / ITEM_GOAL)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 70;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 70;
            end
            default: begin
               send_idle_pct  = 14;
               recv_stall_pct = 14;
            end
         endcase
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_frame(1'b0);
         end else if (pick < 85) begin
            send_frame(1'b1);
         end else if (pick < 95) begin
            for (k = $urandom_range(1, 12); k > 0; k--) begin
               send_req('{($urandom_range(0, 19) == 0) ? FUNC_FLUSH : FUNC_STREAM,
                          8'($urandom)});
            end
         end else begin
            send_req('{FUNC_FLUSH, 8'($urandom)});
         end
      end

      req_valid = 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (bad_fields == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
